// ===== hw/rtl/ttb_pkg.sv =====
// ----------------------------------------------------------------------------
// ttb_pkg
// shared widths, step counts and sequencer states of the tangent/binormal block
// ----------------------------------------------------------------------------
package ttb_pkg;

    localparam int IN_W       = 32;  // corner field width, q16.16
    localparam int DIFF_W     = 33;  // edge difference width
    localparam int PROD_W     = 66;  // serial product accumulator width
    localparam int TERM_W     = 67;  // signed cross term width
    localparam int B_W        = 31;  // pre-scaled magnitude width
    localparam int SQ_W       = 62;  // square of a pre-scaled magnitude
    localparam int S_W        = 64;  // sum of squares
    localparam int OUT_W      = 16;  // q2.14 result width
    localparam int MUL_STEPS  = 33;  // shift-add steps per product
    localparam int DIV_STEPS  = 31;  // quotient bits per division
    localparam int SQRT_STEPS = 16;  // root bits per square root
    localparam int NUM_PRODS  = 14;  // two products for each of seven cross terms

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PLOAD,
        ST_PRUN,
        ST_PACC,
        ST_CHECK,
        ST_VLOAD,
        ST_SHIFT,
        ST_QLOAD,
        ST_QRUN,
        ST_QACC,
        ST_DINIT,
        ST_DIV,
        ST_SINIT,
        ST_SQRT,
        ST_STORE,
        ST_DONE
    } t_state;

endpackage

// ===== hw/rtl/triangle_tangent_binormal.sv =====
// ----------------------------------------------------------------------------
// triangle_tangent_binormal
// per-triangle unit tangent and binormal from corner positions and uv
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one triangle corner per transaction: tdata holds pos_x,
//   pos_y, pos_z, tex_u, tex_v (q16.16), tuser[0] restarts a triangle.
//   corners 0 and 1 are stored and produce no result.
//   corner 2 starts the bit-serial datapath; s_axis_tready stays low until
//   the result is handed to the output register.
//   m_axis carries one result per triangle: six q2.14 vector components in
//   tdata and the degenerate flag in tuser[0].
// sequence after the third corner
//   14 products through one shift-add multiplier, then per vector:
//   magnitude pre-scaling, three squares and three divide + square root
//   passes; a degenerate triangle skips the vector passes.
// reset clears the corner count, the sequencer and the output valid.
// a stalled receiver holds the output register; the next triangle runs
// and then waits in its final state until the register frees up.
// ----------------------------------------------------------------------------
module triangle_tangent_binormal
    import ttb_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v from the lowest bit up
    input  logic [159:0] s_axis_tdata,
    // first_corner
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tangent_x, tangent_y, tangent_z, binormal_x, binormal_y, binormal_z
    output logic [95:0]  m_axis_tdata,
    // degenerate
    output logic [0:0]   m_axis_tuser
);

    t_state r_state, n_state;

    // corner storage
    logic [IN_W-1:0] r_cp_x [2];
    logic [IN_W-1:0] r_cp_y [2];
    logic [IN_W-1:0] r_cp_z [2];
    logic [IN_W-1:0] r_ct_u [2];
    logic [IN_W-1:0] r_ct_v [2];
    logic [1:0]      r_count;

    // edge differences of the current triangle
    logic signed [DIFF_W-1:0] r_du1, r_dv1, r_du2, r_dv2;
    logic signed [DIFF_W-1:0] r_dp1 [3];
    logic signed [DIFF_W-1:0] r_dp2 [3];

    // serial multiplier
    logic [PROD_W-1:0] r_mcand;
    logic [DIFF_W-1:0] r_mplier;
    logic [PROD_W-1:0] r_acc;
    logic              r_pneg;
    logic [5:0]        r_bit;
    logic [3:0]        r_prod;

    // cross terms
    logic signed [TERM_W-1:0] r_part;
    logic signed [TERM_W-1:0] r_cx;
    logic signed [TERM_W-1:0] r_cy [3];
    logic signed [TERM_W-1:0] r_cz [3];
    logic                     r_cxneg;

    // normalization
    logic              r_vec;
    logic [1:0]        r_comp;
    logic [PROD_W-1:0] r_mag [3];
    logic              r_neg [3];
    logic [SQ_W-1:0]   r_sq  [3];
    logic [S_W-1:0]    r_s;
    logic [S_W-1:0]    r_rem;
    logic              r_nbit;
    logic [B_W-1:0]    r_q;
    logic [31:0]       r_qsh;
    logic [19:0]       r_srem;
    logic [15:0]       r_root;

    // results
    logic [OUT_W-1:0] r_res [6];
    logic             r_deg;
    logic [95:0]      r_otdata;
    logic             r_ouser;
    logic             r_ovalid;

    logic in_acc, out_free, third;
    logic [1:0] cnt;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;
    assign cnt      = s_axis_tuser[0] ? 2'd0 : ((r_count == 2'd3) ? 2'd0 : r_count);
    assign third    = (cnt == 2'd2);

    // operand selection for product r_prod: term index in [3:1], subtract in [0]
    logic signed [DIFF_W-1:0] op_a, op_b;
    always_comb begin
        op_a = r_du1;
        op_b = r_dv2;
        case (r_prod[3:1])
            3'd0: begin
                op_a = r_prod[0] ? r_dv1 : r_du1;
                op_b = r_prod[0] ? r_du2 : r_dv2;
            end
            3'd1: begin
                op_a = r_prod[0] ? r_dp1[0] : r_dv1;
                op_b = r_prod[0] ? r_dv2    : r_dp2[0];
            end
            3'd2: begin
                op_a = r_prod[0] ? r_dp1[1] : r_dv1;
                op_b = r_prod[0] ? r_dv2    : r_dp2[1];
            end
            3'd3: begin
                op_a = r_prod[0] ? r_dp1[2] : r_dv1;
                op_b = r_prod[0] ? r_dv2    : r_dp2[2];
            end
            3'd4: begin
                op_a = r_prod[0] ? r_du1    : r_dp1[0];
                op_b = r_prod[0] ? r_dp2[0] : r_du2;
            end
            3'd5: begin
                op_a = r_prod[0] ? r_du1    : r_dp1[1];
                op_b = r_prod[0] ? r_dp2[1] : r_du2;
            end
            3'd6: begin
                op_a = r_prod[0] ? r_du1    : r_dp1[2];
                op_b = r_prod[0] ? r_dp2[2] : r_du2;
            end
            default: begin
                op_a = r_du1;
                op_b = r_dv2;
            end
        endcase
    end

    logic [DIFF_W-1:0] a_mag, b_mag;
    assign a_mag = op_a[DIFF_W-1] ? DIFF_W'(-op_a) : DIFF_W'(op_a);
    assign b_mag = op_b[DIFF_W-1] ? DIFF_W'(-op_b) : DIFF_W'(op_b);

    // signed product from the accumulator
    logic signed [TERM_W-1:0] prod_val, term_val;
    assign prod_val = r_pneg ? -$signed({1'b0, r_acc}) : $signed({1'b0, r_acc});
    assign term_val = r_prod[0] ? (r_part - prod_val) : prod_val;

    // pre-scaling: shift while any magnitude is longer than 31 bits
    logic any_hi;
    assign any_hi = (|r_mag[0][PROD_W-1:B_W]) || (|r_mag[1][PROD_W-1:B_W])
                 || (|r_mag[2][PROD_W-1:B_W]);

    // restoring division step
    logic [S_W:0] div_sh, div_dif;
    logic         div_ge;
    assign div_sh  = {r_rem, r_nbit};
    assign div_dif = div_sh - {1'b0, r_s};
    assign div_ge  = (div_sh >= {1'b0, r_s});

    // square root step, two radicand bits per cycle
    logic [19:0] sq_sh, sq_trial;
    logic        sq_ge;
    assign sq_sh    = {r_srem[17:0], r_qsh[31:30]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign sq_ge    = (sq_sh >= sq_trial);

    // rounding and sign of one component
    logic [16:0]      t_inc;
    logic [OUT_W-1:0] t_mag, t_out;
    logic             t_neg;
    assign t_inc = {1'b0, r_root} + 17'd1;
    assign t_mag = (r_s == '0) ? '0 : t_inc[16:1];
    assign t_neg = (r_neg[r_comp] == r_cxneg);
    assign t_out = t_neg ? OUT_W'(-t_mag) : t_mag;

    logic [2:0] res_idx;
    assign res_idx = (r_vec ? 3'd3 : 3'd0) + {1'b0, r_comp};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (in_acc && third) n_state = ST_PLOAD;
            ST_PLOAD: n_state = ST_PRUN;
            ST_PRUN:  if (r_bit == 6'(MUL_STEPS - 1)) n_state = ST_PACC;
            ST_PACC:  n_state = (r_prod == 4'(NUM_PRODS - 1)) ? ST_CHECK : ST_PLOAD;
            ST_CHECK: n_state = (r_cx == '0) ? ST_DONE : ST_VLOAD;
            ST_VLOAD: n_state = ST_SHIFT;
            ST_SHIFT: if (!any_hi) n_state = ST_QLOAD;
            ST_QLOAD: n_state = ST_QRUN;
            ST_QRUN:  if (r_bit == 6'(MUL_STEPS - 1)) n_state = ST_QACC;
            ST_QACC:  n_state = (r_comp == 2'd2) ? ST_DINIT : ST_QLOAD;
            ST_DINIT: n_state = ST_DIV;
            ST_DIV:   if (r_bit == 6'(DIV_STEPS - 1)) n_state = ST_SINIT;
            ST_SINIT: n_state = ST_SQRT;
            ST_SQRT:  if (r_bit == 6'(SQRT_STEPS - 1)) n_state = ST_STORE;
            ST_STORE: begin
                if (r_comp != 2'd2) n_state = ST_DINIT;
                else n_state = r_vec ? ST_DONE : ST_VLOAD;
            end
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        m_axis_tvalid = r_ovalid;
        m_axis_tdata  = r_otdata;
        m_axis_tuser  = r_ouser;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) r_count <= third ? 2'd0 : cnt + 2'd1;
            if (r_state == ST_DONE && out_free) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (!third) begin
                        r_cp_x[cnt[0]] <= s_axis_tdata[31:0];
                        r_cp_y[cnt[0]] <= s_axis_tdata[63:32];
                        r_cp_z[cnt[0]] <= s_axis_tdata[95:64];
                        r_ct_u[cnt[0]] <= s_axis_tdata[127:96];
                        r_ct_v[cnt[0]] <= s_axis_tdata[159:128];
                    end else begin
                        r_du1 <= $signed({r_ct_u[1][31], r_ct_u[1]})
                               - $signed({r_ct_u[0][31], r_ct_u[0]});
                        r_dv1 <= $signed({r_ct_v[1][31], r_ct_v[1]})
                               - $signed({r_ct_v[0][31], r_ct_v[0]});
                        r_du2 <= $signed({s_axis_tdata[127], s_axis_tdata[127:96]})
                               - $signed({r_ct_u[1][31], r_ct_u[1]});
                        r_dv2 <= $signed({s_axis_tdata[159], s_axis_tdata[159:128]})
                               - $signed({r_ct_v[1][31], r_ct_v[1]});
                        r_dp1[0] <= $signed({r_cp_x[1][31], r_cp_x[1]})
                                  - $signed({r_cp_x[0][31], r_cp_x[0]});
                        r_dp1[1] <= $signed({r_cp_y[1][31], r_cp_y[1]})
                                  - $signed({r_cp_y[0][31], r_cp_y[0]});
                        r_dp1[2] <= $signed({r_cp_z[1][31], r_cp_z[1]})
                                  - $signed({r_cp_z[0][31], r_cp_z[0]});
                        r_dp2[0] <= $signed({s_axis_tdata[31], s_axis_tdata[31:0]})
                                  - $signed({r_cp_x[1][31], r_cp_x[1]});
                        r_dp2[1] <= $signed({s_axis_tdata[63], s_axis_tdata[63:32]})
                                  - $signed({r_cp_y[1][31], r_cp_y[1]});
                        r_dp2[2] <= $signed({s_axis_tdata[95], s_axis_tdata[95:64]})
                                  - $signed({r_cp_z[1][31], r_cp_z[1]});
                        r_prod <= 4'd0;
                    end
                end
            end
            ST_PLOAD: begin
                r_mcand  <= {{(PROD_W-DIFF_W){1'b0}}, a_mag};
                r_mplier <= b_mag;
                r_acc    <= '0;
                r_pneg   <= op_a[DIFF_W-1] ^ op_b[DIFF_W-1];
                r_bit    <= '0;
            end
            ST_PRUN, ST_QRUN: begin
                if (r_mplier[0]) r_acc <= r_acc + r_mcand;
                r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[DIFF_W-1:1]};
                r_bit    <= r_bit + 6'd1;
            end
            ST_PACC: begin
                r_part <= term_val;
                if (r_prod[0]) begin
                    case (r_prod[3:1])
                        3'd0:    r_cx    <= term_val;
                        3'd1:    r_cy[0] <= term_val;
                        3'd2:    r_cy[1] <= term_val;
                        3'd3:    r_cy[2] <= term_val;
                        3'd4:    r_cz[0] <= term_val;
                        3'd5:    r_cz[1] <= term_val;
                        default: r_cz[2] <= term_val;
                    endcase
                end
                r_prod <= r_prod + 4'd1;
            end
            ST_CHECK: begin
                r_cxneg <= r_cx[TERM_W-1];
                r_vec   <= 1'b0;
                if (r_cx == '0) begin
                    r_deg <= 1'b1;
                    for (int i = 0; i < 6; i++) r_res[i] <= '0;
                end else begin
                    r_deg <= 1'b0;
                end
            end
            ST_VLOAD: begin
                for (int i = 0; i < 3; i++) begin
                    logic signed [TERM_W-1:0] tv;
                    tv = r_vec ? r_cz[i] : r_cy[i];
                    r_neg[i] <= tv[TERM_W-1];
                    r_mag[i] <= tv[TERM_W-1] ? PROD_W'(-tv) : tv[PROD_W-1:0];
                end
                r_comp <= 2'd0;
                r_s    <= '0;
            end
            ST_SHIFT: begin
                if (any_hi) begin
                    for (int i = 0; i < 3; i++) r_mag[i] <= {1'b0, r_mag[i][PROD_W-1:1]};
                end
            end
            ST_QLOAD: begin
                r_mcand  <= {{(PROD_W-B_W){1'b0}}, r_mag[r_comp][B_W-1:0]};
                r_mplier <= {{(DIFF_W-B_W){1'b0}}, r_mag[r_comp][B_W-1:0]};
                r_acc    <= '0;
                r_bit    <= '0;
            end
            ST_QACC: begin
                r_sq[r_comp] <= r_acc[SQ_W-1:0];
                r_s          <= r_s + {{(S_W-SQ_W){1'b0}}, r_acc[SQ_W-1:0]};
                r_comp       <= (r_comp == 2'd2) ? 2'd0 : r_comp + 2'd1;
            end
            ST_DINIT: begin
                // dividend is sq << 30; its top part sq >> 1 is already below s
                r_rem  <= {{(S_W-SQ_W+1){1'b0}}, r_sq[r_comp][SQ_W-1:1]};
                r_nbit <= r_sq[r_comp][0];
                r_q    <= '0;
                r_bit  <= '0;
            end
            ST_DIV: begin
                r_rem  <= div_ge ? div_dif[S_W-1:0] : div_sh[S_W-1:0];
                r_nbit <= 1'b0;
                r_q    <= {r_q[B_W-2:0], div_ge};
                r_bit  <= r_bit + 6'd1;
            end
            ST_SINIT: begin
                r_qsh  <= {1'b0, r_q};
                r_srem <= '0;
                r_root <= '0;
                r_bit  <= '0;
            end
            ST_SQRT: begin
                r_qsh  <= {r_qsh[29:0], 2'b00};
                r_srem <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
                r_root <= {r_root[14:0], sq_ge};
                r_bit  <= r_bit + 6'd1;
            end
            ST_STORE: begin
                r_res[res_idx] <= t_out;
                if (r_comp == 2'd2) begin
                    r_comp <= 2'd0;
                    r_vec  <= 1'b1;
                end else begin
                    r_comp <= r_comp + 2'd1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    r_otdata <= {r_res[5], r_res[4], r_res[3], r_res[2], r_res[1], r_res[0]};
                    r_ouser  <= r_deg;
                end
            end
            default: begin
                r_bit <= '0;
            end
        endcase
    end

endmodule
